/* rtl/stgr_pkg.sv */
// ----------------------------------------------------------------------------
// stgr_pkg
// Shared types, constants and helpers of the scaled glyph rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package stgr_pkg;

    // Screen and font defaults
    localparam int ScreenWDefault    = 240;
    localparam int ScreenHDefault    = 320;
    localparam int MaxGlyphColsDflt  = 8;
    localparam int GlyphCount        = 96;
    localparam int StoreDepth        = GlyphCount * 8;
    localparam int StoreAddrW        = $clog2(StoreDepth);

    // Character codes
    localparam logic [7:0] FirstCode   = 8'd32;
    localparam logic [7:0] LastCode    = 8'd127;
    localparam logic [7:0] NewlineCode = 8'd10;

    // Opcodes
    localparam logic [1:0] OpLoad  = 2'd0;
    localparam logic [1:0] OpBegin = 2'd1;
    localparam logic [1:0] OpChar  = 2'd2;

    // Configuration register indexes
    localparam logic [3:0] CfgGlyphWidth  = 4'd0;
    localparam logic [3:0] CfgGlyphHeight = 4'd1;
    localparam logic [3:0] CfgScale       = 4'd2;
    localparam logic [3:0] CfgTextColor   = 4'd3;

    // Configuration reset values
    localparam logic [3:0]  GlyphWidthRst  = 4'd5;
    localparam logic [3:0]  GlyphHeightRst = 4'd7;
    localparam logic [3:0]  ScaleRst       = 4'd1;
    localparam logic [15:0] TextColorRst   = 16'hFFFF;

    localparam logic [10:0] CoordMax = 11'd1023;

    // Controller -> datapath commands
    typedef struct packed {
        logic load;       // write font byte from input transaction
        logic start;      // begin string at origin
        logic item_ld;    // capture character code
        logic newline;    // return to line start, move down
        logic wrap;       // wrap before glyph if past right edge
        logic stop;       // mark string stopped
        logic glyph_ld;   // load glyph base address, clear column
        logic col_inc;    // next glyph column
        logic rd;         // read font column
        logic mask_ld;    // capture column bits
        logic take;       // move lowest set bit into pending block
        logic push;       // pending block to output register
        logic push_last;  // pushed block closes the character
        logic adv;        // advance cursor by one cell
    } stgr_cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic stopped;
        logic is_newline;
        logic wrap_hit;
        logic bottom_hit;
        logic glyph_ok;
        logic mask_zero;
        logic col_last;
        logic pend_valid;
        logic out_free;
    } stgr_stat_t;

    function automatic logic [9:0] sat_coord(input logic [10:0] v);
        return (v > CoordMax) ? CoordMax[9:0] : v[9:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/stgr_ram.sv */
// ----------------------------------------------------------------------------
// stgr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module stgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 768
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/stgr_ctrl.sv */
// ----------------------------------------------------------------------------
// stgr_ctrl
// Sequencer of the glyph rasterizer: decodes items and walks glyph columns.
// ----------------------------------------------------------------------------
`default_nettype none

module stgr_ctrl
    import stgr_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    input  wire logic [1:0] in_op,
    output logic            in_ready,
    input  wire stgr_stat_t stat,
    output stgr_cmd_t       cmd
);

    localparam logic [2:0] StIdle   = 3'd0;
    localparam logic [2:0] StChar   = 3'd1;
    localparam logic [2:0] StBottom = 3'd2;
    localparam logic [2:0] StRead   = 3'd3;
    localparam logic [2:0] StLoad   = 3'd4;
    localparam logic [2:0] StScan   = 3'd5;
    localparam logic [2:0] StFlush  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       accept;

    // no transaction is taken while reset is held
    assign in_ready = aresetn && (state_reg == StIdle);
    assign accept   = in_valid && in_ready;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= StIdle;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            StIdle: begin
                if (accept) begin
                    cmd.load    = (in_op == OpLoad);
                    cmd.start   = (in_op == OpBegin);
                    cmd.item_ld = 1'b1;
                    if (in_op == OpChar && !stat.stopped) begin
                        state_next = StChar;
                    end
                end
            end
            StChar: begin
                if (stat.is_newline) begin
                    cmd.newline = 1'b1;
                    state_next  = StIdle;
                end else begin
                    cmd.wrap   = stat.wrap_hit;
                    state_next = StBottom;
                end
            end
            StBottom: begin
                if (stat.bottom_hit) begin
                    cmd.stop   = 1'b1;
                    state_next = StIdle;
                end else if (stat.glyph_ok) begin
                    cmd.glyph_ld = 1'b1;
                    state_next   = StRead;
                end else begin
                    cmd.adv    = 1'b1;
                    state_next = StIdle;
                end
            end
            StRead: begin
                cmd.rd     = 1'b1;
                state_next = StLoad;
            end
            StLoad: begin
                cmd.mask_ld = 1'b1;
                state_next  = StScan;
            end
            StScan: begin
                if (!stat.mask_zero) begin
                    // a pending block must leave before the next one takes its place
                    if (!stat.pend_valid || stat.out_free) begin
                        cmd.take = 1'b1;
                        cmd.push = stat.pend_valid;
                    end
                end else if (stat.col_last) begin
                    state_next = StFlush;
                end else begin
                    cmd.col_inc = 1'b1;
                    state_next  = StRead;
                end
            end
            StFlush: begin
                if (!stat.pend_valid) begin
                    cmd.adv    = 1'b1;
                    state_next = StIdle;
                end else if (stat.out_free) begin
                    cmd.push      = 1'b1;
                    cmd.push_last = 1'b1;
                    cmd.adv       = 1'b1;
                    state_next    = StIdle;
                end
            end
            default: begin
                state_next = StIdle;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/stgr_dp.sv */
// ----------------------------------------------------------------------------
// stgr_dp
// Datapath: configuration, cursor, font store, bit scan and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module stgr_dp
    import stgr_pkg::*;
#(
    parameter int SCREEN_W       = ScreenWDefault,
    parameter int SCREEN_H       = ScreenHDefault,
    parameter int MAX_GLYPH_COLS = MaxGlyphColsDflt
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [3:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    // input item fields
    input  wire logic [8:0]  origin_x,
    input  wire logic [8:0]  origin_y,
    input  wire logic [7:0]  char_code,
    input  wire logic [9:0]  font_address,
    input  wire logic [7:0]  font_byte,
    // control
    input  wire stgr_cmd_t   cmd,
    output stgr_stat_t       stat,
    // result
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [9:0]       block_x,
    output logic [9:0]       block_y,
    output logic [3:0]       block_size,
    output logic [15:0]      color,
    output logic             last
);

    localparam int          ColW     = $clog2(MAX_GLYPH_COLS);
    localparam logic [3:0]  MaxCols  = 4'(MAX_GLYPH_COLS);
    localparam logic [10:0] ScreenW  = 11'(SCREEN_W);
    localparam logic [10:0] ScreenH  = 11'(SCREEN_H);

    // Configuration registers
    logic [3:0]  glyph_width_reg, glyph_height_reg, scale_factor_reg;
    logic [15:0] text_color_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            glyph_width_reg  <= GlyphWidthRst;
            glyph_height_reg <= GlyphHeightRst;
            scale_factor_reg <= ScaleRst;
            text_color_reg   <= TextColorRst;
        end else if (cfg_we) begin
            if (cfg_index == CfgGlyphWidth)  glyph_width_reg  <= cfg_data[3:0];
            if (cfg_index == CfgGlyphHeight) glyph_height_reg <= cfg_data[3:0];
            if (cfg_index == CfgScale)       scale_factor_reg <= cfg_data[3:0];
            if (cfg_index == CfgTextColor)   text_color_reg   <= cfg_data;
        end
    end

    // Effective glyph geometry
    logic [3:0] scale, cols, rows;
    logic [7:0] step_x, step_y, glyph_h;
    logic [7:0] row_mask;

    assign scale   = (scale_factor_reg == 4'd0) ? 4'd1 : scale_factor_reg;
    assign cols    = (glyph_width_reg > MaxCols) ? MaxCols : glyph_width_reg;
    assign rows    = (glyph_height_reg > 4'd8) ? 4'd8 : glyph_height_reg;
    assign step_x  = (8'(cols) + 8'd1) * 8'(scale);
    assign step_y  = (8'(rows) + 8'd1) * 8'(scale);
    assign glyph_h = 8'(rows) * 8'(scale);
    assign row_mask = (rows == 4'd8) ? 8'hFF : 8'((9'd1 << rows) - 9'd1);

    // Cursor state
    logic [9:0] cursor_col_reg, cursor_row_reg;
    logic [8:0] line_start_reg;
    logic       stopped_reg;
    logic [7:0] char_reg;
    logic [9:0] row_down;

    assign row_down = sat_coord({1'b0, cursor_row_reg} + {3'b0, step_y});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
            line_start_reg <= '0;
            stopped_reg    <= 1'b0;
        end else begin
            if (cmd.start) begin
                line_start_reg <= origin_x;
                cursor_col_reg <= {1'b0, origin_x};
                cursor_row_reg <= {1'b0, origin_y};
                stopped_reg    <= 1'b0;
            end
            if (cmd.newline || cmd.wrap) begin
                cursor_col_reg <= {1'b0, line_start_reg};
                cursor_row_reg <= row_down;
            end
            if (cmd.stop) begin
                stopped_reg <= 1'b1;
            end
            if (cmd.adv) begin
                cursor_col_reg <= sat_coord({1'b0, cursor_col_reg} + {3'b0, step_x});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.item_ld) begin
            char_reg <= char_code;
        end
    end

    // Font store
    logic [StoreAddrW-1:0] base_reg;
    logic [ColW-1:0]       col_reg;
    logic [7:0]            rd_data;
    logic [StoreAddrW-1:0] rd_addr;

    assign rd_addr = base_reg + StoreAddrW'(col_reg);

    stgr_ram #(
        .WIDTH (8),
        .DEPTH (StoreDepth)
    ) u_font_ram (
        .aclk    (aclk),
        .wr_en   (cmd.load && ({1'b0, font_address} < 11'(StoreDepth))),
        .wr_addr (StoreAddrW'(font_address)),
        .wr_data (font_byte),
        .rd_en   (cmd.rd),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Column walk
    logic [9:0] colx_reg;
    logic [7:0] mask_reg;

    always_ff @(posedge aclk) begin
        if (cmd.glyph_ld) begin
            base_reg <= StoreAddrW'(char_reg - FirstCode) * StoreAddrW'(cols);
            col_reg  <= '0;
        end else if (cmd.col_inc) begin
            col_reg <= col_reg + ColW'(1);
        end
        if (cmd.rd) begin
            colx_reg <= sat_coord({1'b0, cursor_col_reg} + 11'(col_reg) * 11'(scale));
        end
    end

    // Lowest set row of the column
    logic [2:0] row_idx;
    logic [9:0] rowy;

    always_comb begin
        row_idx = '0;
        for (int i = 7; i >= 0; i--) begin
            if (mask_reg[i]) row_idx = 3'(i);
        end
    end

    assign rowy = sat_coord({1'b0, cursor_row_reg} + 11'(row_idx) * 11'(scale));

    always_ff @(posedge aclk) begin
        if (cmd.mask_ld) begin
            mask_reg <= rd_data & row_mask;
        end else if (cmd.take) begin
            mask_reg <= mask_reg & ~(8'd1 << row_idx);
        end
    end

    // Pending block, held back one step to mark the last one
    logic       pend_valid_reg;
    logic [9:0] pend_x_reg, pend_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else if (cmd.take) begin
            pend_valid_reg <= 1'b1;
        end else if (cmd.push) begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            pend_x_reg <= colx_reg;
            pend_y_reg <= rowy;
        end
    end

    // Output register
    logic out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.push) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            block_x    <= pend_x_reg;
            block_y    <= pend_y_reg;
            block_size <= scale;
            color      <= text_color_reg;
            last       <= cmd.push_last;
        end
    end

    assign out_valid = out_valid_reg;

    // Status
    always_comb begin
        stat.stopped    = stopped_reg;
        stat.is_newline = (char_reg == NewlineCode);
        stat.wrap_hit   = ({1'b0, cursor_col_reg} + {3'b0, step_x}) > ScreenW;
        stat.bottom_hit = ({1'b0, cursor_row_reg} + {3'b0, glyph_h}) > ScreenH;
        stat.glyph_ok   = (char_reg >= FirstCode) && (char_reg <= LastCode)
                          && (cols != 4'd0);
        stat.mask_zero  = (mask_reg == 8'd0);
        stat.col_last   = (4'(col_reg) + 4'd1) == cols;
        stat.pend_valid = pend_valid_reg;
        stat.out_free   = !out_valid_reg || out_ready;
    end

endmodule

`default_nettype wire

/* rtl/scaled_text_glyph_rasterizer_top.sv */
// ----------------------------------------------------------------------------
// scaled_text_glyph_rasterizer_top
// Text renderer with a loadable column-major font; emits one square block
// per set glyph bit.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake            Payload
//  s_*       in   s_tvalid/s_tready    load, begin or character item
//  m_*       out  m_tvalid/m_tready    pixel block, m_tlast on last of glyph
//  cfg_*     in   cfg_valid/cfg_ready  register index and write data
//
//  Load and begin items are taken in the idle state. A newline passes the
//  decode state only; a character also passes a bottom check and, per glyph
//  column, a font RAM read, a mask load and a scan of each set bit, then a flush.
//  Reset clears cursor, control and config; the font store is not cleared.
//  A stalled m_tready holds the bit scan; s_tready is low while a character
//  is in work.
// ----------------------------------------------------------------------------
`default_nettype none

module scaled_text_glyph_rasterizer_top
    import stgr_pkg::*;
#(
    parameter int SCREEN_W       = ScreenWDefault,
    parameter int SCREEN_H       = ScreenHDefault,
    parameter int MAX_GLYPH_COLS = MaxGlyphColsDflt
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // origin_x[8:0], origin_y[17:9], char_code[25:18], font_address[35:26],
    // font_byte[43:36], zero fill [47:44]
    input  wire logic [47:0] s_tdata,
    // opcode[1:0]
    input  wire logic [1:0]  s_tuser,
    // result blocks
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // block_x[9:0], block_y[19:10], block_size[23:20], color[39:24]
    output logic [39:0]      m_tdata,
    output logic             m_tlast,
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [3:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    stgr_cmd_t  cmd;
    stgr_stat_t stat;
    logic [9:0]  block_x, block_y;
    logic [3:0]  block_size;
    logic [15:0] color;

    // register writes are taken whenever reset is released
    assign cfg_ready = aresetn;

    stgr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_op    (s_tuser),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    stgr_dp #(
        .SCREEN_W       (SCREEN_W),
        .SCREEN_H       (SCREEN_H),
        .MAX_GLYPH_COLS (MAX_GLYPH_COLS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .origin_x     (s_tdata[8:0]),
        .origin_y     (s_tdata[17:9]),
        .char_code    (s_tdata[25:18]),
        .font_address (s_tdata[35:26]),
        .font_byte    (s_tdata[43:36]),
        .cmd          (cmd),
        .stat         (stat),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .block_x      (block_x),
        .block_y      (block_y),
        .block_size   (block_size),
        .color        (color),
        .last         (m_tlast)
    );

    assign m_tdata = {color, block_size, block_y, block_x};

endmodule

`default_nettype wire

/* test/tb_scaled_text_glyph_rasterizer_top.sv */
// ----------------------------------------------------------------------------
// tb_scaled_text_glyph_rasterizer_top
// Self-checking bench for the glyph rasterizer. The glyphs that the strings
// use are loaded with random bytes first. A short table of directed items
// follows, then random strings over several register settings. Every accepted
// item runs through a local predictor, and each block on the result stream is
// compared field by field with the oldest predicted block.
// ----------------------------------------------------------------------------

module tb_scaled_text_glyph_rasterizer_top
    import stgr_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OpUnused   = 2'd3;
    localparam int         PhaseCount = 7;
    localparam int         PhaseItems = 14;
    localparam int         SettleCyc  = 150;

    // Loaded part of the font store: the first glyphs at the widest stride,
    // plus the highest printable glyph at the reset width
    localparam int LoadedGlyphs  = 8;
    localparam int LoadedCols    = LoadedGlyphs * MaxGlyphColsDflt;
    localparam int LastGlyphBase = int'(LastCode - FirstCode) * int'(GlyphWidthRst);
    localparam int FillCount     = LoadedCols + int'(GlyphWidthRst);

    // How an item's blocks are checked
    typedef enum logic [1:0] {ChkPredict, ChkNone, ChkBlock} row_check_t;

    typedef struct packed {
        logic [9:0]  x;
        logic [9:0]  y;
        logic [3:0]  side;
        logic [15:0] color;
        logic        last;
    } block_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [47:0] data;
        row_check_t  chk;
        block_t      blk;
    } dir_row_t;

    // DUT ports
    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = OpLoad;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    // Predictor state
    logic [7:0]  font_mem [0:StoreDepth-1];
    int          cur_x, cur_y, line_x;
    bit          text_stopped;
    int          cfg_w, cfg_h, cfg_scale;
    logic [15:0] cfg_color;

    block_t      expected_blocks[$];
    block_t      got, want;
    block_t      typed_blk   = '0;
    row_check_t  row_check   = ChkPredict;
    dir_row_t    dir_rows[$];

    bit          send_idle   = 1'b1;
    bit          sink_idle   = 1'b1;
    int          stall_left  = 0;

    int          error_count = 0;
    int          item_count  = 0;
    int          char_count  = 0;
    int          block_count = 0;
    int          cfg_count   = 0;
    int          wrap_count  = 0;
    int          stop_count  = 0;

    scaled_text_glyph_rasterizer_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("FAIL scaled_text_glyph_rasterizer_top");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    function automatic int clamp_coord(input int v);
        return (v > 1023) ? 1023 : v;
    endfunction

    function automatic logic [47:0] pack_item(input logic [8:0] ox, input logic [8:0] oy,
                                              input logic [7:0] ch, input logic [9:0] addr,
                                              input logic [7:0] fb);
        return {4'b0, fb, addr, ch, oy, ox};
    endfunction

    // A control code, a high code, or a glyph in the loaded part of the store
    function automatic logic [7:0] pick_code(input logic [7:0] r);
        logic [7:0] code;
        case (r[7:6])
            2'd0:    code = {3'b0, r[4:0]};
            2'd1:    code = {2'b10, r[5:0]};
            2'd2:    code = {2'b11, r[5:0]};
            default: code = FirstCode + {5'b0, r[2:0]};
        endcase
        return code;
    endfunction

    // Advance the text state by one item; queue the blocks it draws when asked
    function automatic void render_item(input logic [1:0] op, input logic [47:0] d,
                                        input bit keep);
        int         s, cols, rows, step_x, step_y, base, n;
        logic [7:0] ch, col_bits;
        block_t     blk;
        ch = d[25:18];
        n  = 0;
        if (op == OpLoad) begin
            if (d[35:26] < StoreDepth)
                font_mem[d[35:26]] = d[43:36];
        end else if (op == OpBegin) begin
            line_x       = d[8:0];
            cur_x        = d[8:0];
            cur_y        = d[17:9];
            text_stopped = 1'b0;
        end else if (op == OpChar && !text_stopped) begin
            s      = (cfg_scale == 0) ? 1 : cfg_scale;
            cols   = (cfg_w > MaxGlyphColsDflt) ? MaxGlyphColsDflt : cfg_w;
            rows   = (cfg_h > 8) ? 8 : cfg_h;
            step_x = (cols + 1) * s;
            step_y = (rows + 1) * s;
            if (ch == NewlineCode) begin
                cur_x = line_x;
                cur_y = clamp_coord(cur_y + step_y);
            end else begin
                // wrap before drawing if the cell crosses the right edge
                if (cur_x + step_x > ScreenWDefault) begin
                    cur_x = line_x;
                    cur_y = clamp_coord(cur_y + step_y);
                    wrap_count++;
                end
                if (cur_y + rows * s > ScreenHDefault) begin
                    text_stopped = 1'b1;
                    stop_count++;
                end else begin
                    if (ch >= FirstCode && ch <= LastCode) begin
                        base = (ch - FirstCode) * cols;
                        for (int c = 0; c < cols; c++) begin
                            col_bits = font_mem[base + c];
                            for (int r = 0; r < rows; r++) begin
                                if (col_bits[r]) begin
                                    blk.x     = clamp_coord(cur_x + c * s);
                                    blk.y     = clamp_coord(cur_y + r * s);
                                    blk.side  = s[3:0];
                                    blk.color = cfg_color;
                                    blk.last  = 1'b0;
                                    if (keep)
                                        expected_blocks.push_back(blk);
                                    n++;
                                end
                            end
                        end
                        if (keep && n > 0)
                            expected_blocks[$].last = 1'b1;
                    end
                    cur_x = clamp_coord(cur_x + step_x);
                end
            end
        end
    endfunction

    // Result check, register mirror and prediction, all sampled at the edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            cur_x        = 0;
            cur_y        = 0;
            line_x       = 0;
            text_stopped = 1'b0;
            cfg_w        = GlyphWidthRst;
            cfg_h        = GlyphHeightRst;
            cfg_scale    = ScaleRst;
            cfg_color    = TextColorRst;
        end else begin
            if (m_tvalid && m_tready) begin
                got = {m_tdata[9:0], m_tdata[19:10], m_tdata[23:20], m_tdata[39:24], m_tlast};
                block_count++;
                if (expected_blocks.size() == 0) begin
                    report_mismatch($sformatf("block at (%0d,%0d) with none expected",
                                              got.x, got.y));
                end else begin
                    want = expected_blocks.pop_front();
                    if (got.x !== want.x)
                        report_mismatch($sformatf("block_x %0d, expected %0d", got.x, want.x));
                    if (got.y !== want.y)
                        report_mismatch($sformatf("block_y %0d, expected %0d", got.y, want.y));
                    if (got.side !== want.side)
                        report_mismatch($sformatf("block_size %0d, expected %0d",
                                                  got.side, want.side));
                    if (got.color !== want.color)
                        report_mismatch($sformatf("color %h, expected %h",
                                                  got.color, want.color));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("tlast %b, expected %b", got.last, want.last));
                end
            end
            if (cfg_valid && cfg_ready) begin
                cfg_count++;
                case (cfg_index)
                    CfgGlyphWidth:  cfg_w     = cfg_data[3:0];
                    CfgGlyphHeight: cfg_h     = cfg_data[3:0];
                    CfgScale:       cfg_scale = cfg_data[3:0];
                    CfgTextColor:   cfg_color = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                item_count++;
                if (s_tuser == OpChar)
                    char_count++;
                render_item(s_tuser, s_tdata, row_check == ChkPredict);
                if (row_check == ChkBlock)
                    expected_blocks.push_back(typed_blk);
            end
        end
    end

    // Result-side backpressure: random stall bursts while the sink may idle
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (sink_idle && $urandom_range(0, 11) == 0) begin
            stall_left <= $urandom_range(0, 12);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // One input transaction, with an optional idle burst after it
    task automatic push_item(input logic [1:0] op, input logic [47:0] data,
                             input row_check_t chk);
        s_tuser   <= op;
        s_tdata   <= data;
        row_check <= chk;
        s_tvalid  <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        if (send_idle && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
    endtask

    // One register write; the caller drops cfg_valid after the last one
    task automatic write_cfg(input logic [3:0] index, input logic [15:0] value);
        cfg_index <= index;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Wait for every expected block, then give a character with no blocks time to finish
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_blocks.size() != 0);
        repeat (SettleCyc) @(posedge aclk);
    endtask

    task automatic add_row(input logic [1:0] op, input logic [8:0] ox, input logic [8:0] oy,
                           input logic [7:0] ch, input logic [9:0] addr, input logic [7:0] fb,
                           input row_check_t chk, input logic [9:0] bx, input logic [9:0] by);
        dir_row_t row;
        row.op   = op;
        row.data = pack_item(ox, oy, ch, addr, fb);
        row.chk  = chk;
        row.blk  = {bx, by, ScaleRst, TextColorRst, 1'b1};
        dir_rows.push_back(row);
    endtask

    initial begin
        int          phase_items, n_chars, fill_addr;
        logic [63:0] junk;
        logic [8:0]  ox, oy;
        logic [7:0]  ch;
        logic [3:0]  w, h, sc;
        logic [15:0] col;
        bit          nl_burst;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Fill the used glyphs; about a quarter of the columns are empty
        for (int a = 0; a < FillCount; a++) begin
            fill_addr = (a < LoadedCols) ? a : LastGlyphBase + a - LoadedCols;
            junk = {$urandom(), $urandom()};
            push_item(OpLoad, pack_item(junk[8:0], junk[17:9], junk[25:18], 10'(fill_addr),
                      ($urandom_range(0, 3) == 0) ? 8'h00 : junk[33:26]), ChkPredict);
        end

        // Directed items under reset settings: 5x7 glyphs, scale 1, white.
        // '!' gets one bit in row 0 and one in row 7, below a 7-row glyph.
        add_row(OpLoad,   0,   0,   0,   5, 8'h81, ChkNone,  0, 0);
        add_row(OpLoad,   0,   0,   0,   6, 8'h00, ChkNone,  0, 0);
        add_row(OpLoad,   0,   0,   0,   7, 8'h00, ChkNone,  0, 0);
        add_row(OpLoad,   0,   0,   0,   8, 8'h00, ChkNone,  0, 0);
        add_row(OpLoad,   0,   0,   0,   9, 8'h00, ChkNone,  0, 0);
        add_row(OpChar,   0,   0,  33,   0, 0,     ChkBlock, 0, 0);    // cursor from reset
        add_row(OpChar,   0,   0,  NewlineCode, 0, 0, ChkNone, 0, 0);
        add_row(OpChar,   0,   0,   0,   0, 0,     ChkNone,  0, 0);    // lowest code, moves only
        add_row(OpChar,   0,   0, 255,   0, 0,     ChkNone,  0, 0);    // highest code, moves only
        add_row(OpUnused, 9'h1FF, 9'h1FF, 8'hFF, 10'h3FF, 8'hFF, ChkNone, 0, 0);
        add_row(OpLoad,   0,   0,   0, 10'h3FF, 8'hFF, ChkNone, 0, 0); // address past the store
        add_row(OpChar,   0,   0,  33,   0, 0,     ChkBlock, 12, 8);
        add_row(OpBegin, 9'h1FF, 9'h1FF, 0, 0, 0,  ChkNone,  0, 0);
        add_row(OpChar,   0,   0,  32,   0, 0,     ChkNone,  0, 0);    // wraps, then stops
        add_row(OpChar,   0,   0,  33,   0, 0,     ChkNone,  0, 0);    // string stopped
        add_row(OpChar,   0,   0,  NewlineCode, 0, 0, ChkNone, 0, 0);  // stopped newline
        add_row(OpBegin, 234,  0,   0,   0, 0,     ChkNone,  0, 0);
        add_row(OpChar,   0,   0,  33,   0, 0,     ChkBlock, 234, 0);  // cell ends on the edge
        add_row(OpChar,   0,   0,  33,   0, 0,     ChkBlock, 234, 8);  // wraps to line start
        add_row(OpBegin,  0, 313,   0,   0, 0,     ChkNone,  0, 0);
        add_row(OpChar,   0,   0,  33,   0, 0,     ChkBlock, 0, 313);  // glyph ends on the bottom
        add_row(OpChar,   0,   0,  NewlineCode, 0, 0, ChkNone, 0, 0);
        add_row(OpChar,   0,   0,  33,   0, 0,     ChkNone,  0, 0);    // bottom stop
        add_row(OpBegin, 100, 100,  0,   0, 0,     ChkNone,  0, 0);
        add_row(OpChar,   0,   0, LastCode, 0, 0,  ChkPredict, 0, 0);
        foreach (dir_rows[i]) begin
            typed_blk <= dir_rows[i].blk;
            push_item(dir_rows[i].op, dir_rows[i].data, dir_rows[i].chk);
        end
        settle();

        // Random strings over a series of register settings
        for (int ph = 0; ph < PhaseCount; ph++) begin
            junk = {$urandom(), $urandom()};
            case (ph)
                0: {w, h, sc, col} = {4'd8,  4'd8,  4'd1,  junk[47:32]};
                1: {w, h, sc, col} = {4'd1,  4'd1,  4'd0,  16'h0000};
                2: {w, h, sc, col} = {4'd8,  4'd8,  4'd8,  junk[47:32]};
                3: {w, h, sc, col} = {4'd15, 4'd15, 4'd15, 16'hFFFF};
                4: {w, h, sc, col} = {4'd0,  4'd0,  4'd2,  junk[47:32]};
                5: {w, h, sc, col} = {4'd3,  4'd5,  4'd2,  junk[47:32]};
                default: {w, h, sc, col} = {4'd5, 4'd7, 4'd1, 16'hA5A5};
            endcase
            write_cfg(CfgGlyphWidth,  {junk[11:0], w});
            write_cfg(CfgGlyphHeight, {junk[23:12], h});
            write_cfg(CfgScale,       {junk[31:20], sc});
            write_cfg(CfgTextColor,   col);
            write_cfg(4'($urandom_range(4, 15)), junk[63:48]);
            cfg_valid <= 1'b0;
            // the closing phase runs with no idling on either side
            send_idle = (ph < PhaseCount - 1) && (ph != 3);
            sink_idle = (ph < PhaseCount - 1) && (ph != 1);

            phase_items = 0;
            while (phase_items < PhaseItems) begin
                junk = {$urandom(), $urandom()};
                case ($urandom_range(0, 9))
                    0: begin
                        // noise: any opcode, random fields and a picked code
                        push_item(junk[1:0], pack_item(junk[10:2], junk[19:11],
                                  pick_code(junk[27:20]), junk[37:28], junk[45:38]),
                                  ChkPredict);
                        phase_items++;
                    end
                    1: begin
                        push_item(OpLoad, pack_item(junk[8:0], junk[17:9], junk[25:18],
                                  10'($urandom_range(0, LoadedCols - 1)), junk[33:26]),
                                  ChkPredict);
                        phase_items++;
                    end
                    default: begin
                        if ($urandom_range(0, 4) == 0) begin
                            ox = junk[8:0];
                            oy = junk[17:9];
                        end else begin
                            ox = $urandom_range(0, ScreenWDefault - 1);
                            oy = $urandom_range(0, ScreenHDefault - 1);
                        end
                        push_item(OpBegin, pack_item(ox, oy, junk[25:18], junk[35:26],
                                  junk[43:36]), ChkPredict);
                        phase_items++;
                        // now and then a run of newlines to push the cursor to its limit
                        nl_burst = ($urandom_range(0, 9) == 0);
                        n_chars  = nl_burst ? $urandom_range(10, 14) : $urandom_range(2, 14);
                        for (int k = 0; k < n_chars; k++) begin
                            junk = {$urandom(), $urandom()};
                            if ((nl_burst && k < n_chars - 1) || $urandom_range(0, 9) == 0)
                                ch = NewlineCode;
                            else if ($urandom_range(0, 8) == 0)
                                ch = pick_code(junk[63:56]);
                            else
                                ch = FirstCode + 8'($urandom_range(0, LoadedGlyphs - 1));
                            push_item(OpChar, pack_item(junk[8:0], junk[17:9], ch,
                                      junk[27:18], junk[35:28]), ChkPredict);
                            phase_items++;
                        end
                    end
                endcase
            end
            settle();
        end

        $display("Run covered %0d input transactions (%0d characters), %0d config writes",
                 item_count, char_count, cfg_count);
        $display("Checked %0d blocks; %0d right-edge wraps, %0d strings stopped at the bottom",
                 block_count, wrap_count, stop_count);
        if (error_count == 0) begin
            $display("PASS scaled_text_glyph_rasterizer_top");
        end else begin
            $display("FAIL scaled_text_glyph_rasterizer_top");
        end
        $finish;
    end

endmodule
